// ===== sv/shapad_pkg.sv =====
// shapad_pkg: shared types and constants of the sha message padder
// used by shapad_ctrl, shapad_dp and sha_message_padder; no dependencies
`timescale 1ns / 1ps

package shapad_pkg;

    // padding marker byte that follows the last message byte
    localparam logic [7:0] PAD_MARKER = 8'h80;

    // last word index in a block, 64-byte and 128-byte mode
    localparam logic [4:0] LAST_WORD_64  = 5'd15;
    localparam logic [4:0] LAST_WORD_128 = 5'd31;

    // first word index of the length field (448 and 896 bits into the block)
    localparam logic [4:0] LEN_WORD_64  = 5'd14;
    localparam logic [4:0] LEN_WORD_128 = 5'd28;

    // input kind codes
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_PAD  = 2'b10
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take_byte;
        logic start_pad;
        logic emit_pad;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic load_ok;
        logic last_pad;
    } t_status;

endpackage

// ===== sv/sha_message_padder.sv =====
// sha_message_padder: top level of the sha-2 message padding front end
// depends on shapad_pkg, shapad_ctrl and shapad_dp
`timescale 1ns / 1ps

// usage
//   input channel (i_in_valid / o_in_ready): one beat per message byte with
//   i_kind = 0, then one beat with i_kind = 1 to close the message
//   output channel (o_out_valid / i_out_ready): one beat per 32-bit word,
//   earliest byte in bits 7:0, o_block_end on the last word of each block,
//   o_message_end on the final padded word
//   config channel (i_cfg_valid / o_cfg_ready): bit 0 selects 128-byte
//   blocks; write it only while the block is idle
// timing
//   data bytes are taken one per cycle while the output register can take a
//   word; a completed word shows up on the output in the cycle after its fourth byte
//   an end-of-message beat starts padding: 3 to 36 words, one per cycle
//   unless the receiver stalls, paced by the single output register; no
//   input is taken until the last padded word is loaded into that register
// reset and stall
//   reset clears the byte counter, the partial word, the mode (64-byte
//   blocks) and the output valid flag
//   while the receiver stalls the output word holds and the input stalls
//   once the output register is full and not being drained
module sha_message_padder
    import shapad_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    // input item channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_data_byte,
    // output word channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_word,
    output logic        o_block_end,
    output logic        o_message_end
);

    t_cmd    cmd;
    t_status status;

    // mode register always takes a write
    assign o_cfg_ready = 1'b1;

    shapad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    shapad_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_data_byte   (i_data_byte),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_word        (o_word),
        .o_block_end   (o_block_end),
        .o_message_end (o_message_end)
    );

endmodule

// ===== sv/shapad_ctrl.sv =====
// shapad_ctrl: idle / padding state machine of the sha message padder
// depends on shapad_pkg; drives commands into shapad_dp
`timescale 1ns / 1ps

module shapad_ctrl
    import shapad_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_kind,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   in_beat;

    assign o_in_ready = (r_state == ST_IDLE) && i_status.load_ok;
    assign in_beat    = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.take_byte = in_beat && (i_kind == KIND_DATA);
        o_cmd.start_pad = in_beat && (i_kind == KIND_END);
        o_cmd.emit_pad  = (r_state == ST_PAD) && i_status.load_ok;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.start_pad) n_state = ST_PAD;
            end
            ST_PAD: begin
                if (o_cmd.emit_pad && i_status.last_pad) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/shapad_dp.sv =====
// shapad_dp: byte packing, padding word builder and output register
// depends on shapad_pkg; commanded by shapad_ctrl
`timescale 1ns / 1ps

module shapad_dp
    import shapad_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_data,
    input  logic [7:0]  i_data_byte,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_word,
    output logic        o_block_end,
    output logic        o_message_end
);

    logic        r_block_mode;
    logic [31:0] r_byte_count;
    logic [23:0] r_partial;
    logic [4:0]  r_widx;
    logic        r_first;
    logic        r_extra;
    logic        r_out_valid;
    logic [31:0] r_word;
    logic        r_block_end;
    logic        r_msg_end;

    logic [4:0]  wmask;
    logic [4:0]  len_word;
    logic [4:0]  start_widx;
    logic [1:0]  lane;
    logic        load_ok;
    logic        word_done;
    logic [31:0] byte_word;
    logic        byte_blk_end;
    logic [31:0] pad_word;
    logic        pad_blk_end;
    logic        pad_last;
    logic [31:0] len_bits;

    assign wmask      = r_block_mode ? LAST_WORD_128 : LAST_WORD_64;
    assign len_word   = r_block_mode ? LEN_WORD_128 : LEN_WORD_64;
    assign start_widx = r_byte_count[6:2] & wmask;
    assign lane       = r_byte_count[1:0];
    assign load_ok    = !r_out_valid || i_out_ready;
    assign len_bits   = {r_byte_count[28:0], 3'b000};

    // data byte path
    assign word_done    = (lane == 2'd3);
    assign byte_word    = {i_data_byte, r_partial};
    assign byte_blk_end = (start_widx == wmask);

    // padding word path, one word per beat
    assign pad_blk_end = (r_widx == wmask);
    assign pad_last    = !r_first && !r_extra && pad_blk_end;

    always_comb begin
        pad_word = 32'd0;
        if (r_first) begin
            pad_word = {8'd0, r_partial} | ({24'd0, PAD_MARKER} << {lane, 3'b000});
        end else if (r_extra) begin
            pad_word = 32'd0;
        end else if (pad_blk_end) begin
            // low 32 bits of the length, big-endian
            pad_word = {len_bits[7:0], len_bits[15:8], len_bits[23:16], len_bits[31:24]};
        end else if (r_widx == (wmask - 5'd1)) begin
            // length bits 34:32 land in the last byte of this word
            pad_word = {5'd0, r_byte_count[31:29], 24'd0};
        end
    end

    assign o_status.load_ok  = load_ok;
    assign o_status.last_pad = pad_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_mode <= 1'b0;
            r_byte_count <= 32'd0;
            r_partial    <= 24'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) r_block_mode <= i_cfg_data;

            if (i_cmd.take_byte) begin
                r_byte_count <= r_byte_count + 32'd1;
                if (word_done) begin
                    r_partial <= 24'd0;
                end else begin
                    r_partial <= r_partial | ({16'd0, i_data_byte} << {lane, 3'b000});
                end
            end else if (i_cmd.emit_pad && pad_last) begin
                r_byte_count <= 32'd0;
                r_partial    <= 24'd0;
            end

            if (load_ok) begin
                r_out_valid <= (i_cmd.take_byte && word_done) || i_cmd.emit_pad;
            end
        end
    end

    // padding walk and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_pad) begin
            r_widx  <= start_widx;
            r_first <= 1'b1;
            // marker falls inside the length field, short of its last word: one more whole block
            r_extra <= (start_widx >= len_word) && (start_widx != wmask);
        end else if (i_cmd.emit_pad) begin
            r_widx  <= (r_widx + 5'd1) & wmask;
            r_first <= 1'b0;
            if (!r_first && pad_blk_end) r_extra <= 1'b0;
        end

        if (i_cmd.take_byte && word_done) begin
            r_word      <= byte_word;
            r_block_end <= byte_blk_end;
            r_msg_end   <= 1'b0;
        end else if (i_cmd.emit_pad) begin
            r_word      <= pad_word;
            r_block_end <= pad_blk_end;
            r_msg_end   <= pad_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_word        = r_word;
    assign o_block_end   = r_block_end;
    assign o_message_end = r_msg_end;

endmodule

// ===== verif/padder_check_pkg.sv =====
// padder_check_pkg: expected-word tracker for the sha message padder bench
// depends on shapad_pkg for the input kind codes and the padding marker
`timescale 1ns / 1ps

package padder_check_pkg;
    import shapad_pkg::*;

    // block size selection written through the config channel
    localparam logic MODE_64  = 1'b0;
    localparam logic MODE_128 = 1'b1;

    typedef struct packed {
        logic [31:0] word;
        logic        block_end;
        logic        message_end;
    } padded_word_t;

    class padded_word_checker;
        logic         wide_blocks;
        logic [31:0]  byte_count;
        logic [31:0]  word_in_progress;
        padded_word_t words_due[$];
        int           mismatches;
        int           words_checked;

        function new();
            wide_blocks      = MODE_64;
            byte_count       = '0;
            word_in_progress = '0;
            mismatches       = 0;
            words_checked    = 0;
        endfunction

        function void set_mode(logic mode);
            wide_blocks = mode;
        endfunction

        function int words_pending();
            return words_due.size();
        endfunction

        // place one byte in its lane, queue the word once the fourth lane fills
        function void pack_byte(logic [7:0] b);
            logic [1:0]   lane;
            int unsigned  block_bytes;
            padded_word_t w;
            lane        = byte_count[1:0];
            block_bytes = (wide_blocks == MODE_128) ? 128 : 64;
            word_in_progress[8*lane +: 8] = b;
            byte_count = byte_count + 32'd1;
            if (lane == 2'd3) begin
                w.word        = word_in_progress;
                w.block_end   = ((byte_count & (block_bytes - 1)) == 0);
                w.message_end = 1'b0;
                words_due.push_back(w);
                word_in_progress = '0;
            end
        endfunction

        // predict the words caused by one accepted input beat
        function void accept_item(logic kind, logic [7:0] data_byte);
            logic [63:0] length_bits;
            int unsigned block_bytes;
            int unsigned length_bytes;
            int unsigned sig;
            if (kind == KIND_DATA) begin
                pack_byte(data_byte);
            end else begin
                block_bytes  = (wide_blocks == MODE_128) ? 128 : 64;
                length_bytes = (wide_blocks == MODE_128) ? 16 : 8;
                length_bits  = {29'd0, byte_count, 3'b000};
                pack_byte(PAD_MARKER);
                while ((byte_count & (block_bytes - 1)) != block_bytes - length_bytes)
                    pack_byte(8'h00);
                for (int i = 0; i < length_bytes; i++) begin
                    sig = length_bytes - 1 - i;
                    pack_byte((sig < 8) ? length_bits[8*sig +: 8] : 8'h00);
                end
                words_due[words_due.size() - 1].message_end = 1'b1;
                byte_count       = '0;
                word_in_progress = '0;
            end
        endfunction

        function void check_word(logic [31:0] word, logic block_end, logic message_end);
            padded_word_t due;
            if (words_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %08h block_end %0b message_end %0b",
                             word, block_end, message_end);
                return;
            end
            due = words_due.pop_front();
            words_checked++;
            if (due.word !== word || due.block_end !== block_end
                    || due.message_end !== message_end) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word mismatch: expected %08h/%0b/%0b got %08h/%0b/%0b",
                             due.word, due.block_end, due.message_end,
                             word, block_end, message_end);
            end
        endfunction
    endclass

endpackage

// ===== verif/tb_sha_message_padder.sv =====
// tb_sha_message_padder: self-checking bench for the sha-2 message padder
// depends on shapad_pkg, padder_check_pkg and the sha_message_padder rtl
`timescale 1ns / 1ps

module tb_sha_message_padder;
    import shapad_pkg::*;
    import padder_check_pkg::*;

    // cycles allowed after the last due word before a mode write or the end
    localparam int SETTLE_CYCLES = 4;
    // cycles without any accepted beat before the run is declared hung
    localparam int HANG_LIMIT    = 2000;
    localparam int TARGET_ITEMS  = 110;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data  = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic        i_kind      = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_word;
    logic        o_block_end;
    logic        o_message_end;

    padded_word_checker stream;

    // bookkeeping for the summary and the idle-free stretch
    int  items_sent  = 0;
    int  data_beats  = 0;
    int  end_beats   = 0;
    int  mode_writes = 0;
    bit  calm        = 1'b0;
    int  idle_cycles = 0;

    sha_message_padder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_word        (o_word),
        .o_block_end   (o_block_end),
        .o_message_end (o_message_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: stalls at random with a chance of 23 in 100, never during the calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= 23);
        end
    end

    // output monitor: every accepted word beat is checked against the oldest due word
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            stream.check_word(o_word, o_block_end, o_message_end);
    end

    // hang watchdog: restarts on any accepted beat on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= HANG_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", HANG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // present one input beat after a random gap, return once it is accepted
    task automatic send_item(logic kind, logic [7:0] data_byte);
        while (!calm && $urandom_range(0, 99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= data_byte;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        stream.accept_item(kind, data_byte);
        items_sent++;
        if (kind == KIND_DATA)
            data_beats++;
        else
            end_beats++;
        // no gaps on either side for a stretch in the middle of the run
        calm = (items_sent >= 40 && items_sent < 80);
    endtask

    // drop valid, wait for every due word, then give the pipe time to empty
    task automatic let_block_settle();
        i_in_valid <= 1'b0;
        while (stream.words_pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mode write, only with nothing in flight
    task automatic write_mode(logic mode);
        let_block_settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        stream.set_mode(mode);
        mode_writes++;
    endtask

    task automatic send_message(int unsigned length);
        for (int unsigned i = 0; i < length; i++)
            send_item(KIND_DATA, 8'($urandom_range(0, 255)));
        send_item(KIND_END, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int unsigned length;
        int unsigned room;
        stream = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message in 64-byte mode, ignored byte on the end beat
        write_mode(MODE_64);
        send_item(KIND_END, 8'hFF);
        // byte extremes, one full word plus a partial word
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'hA5);
        send_item(KIND_DATA, 8'h3C);
        send_item(KIND_DATA, 8'h81);
        send_item(KIND_END, 8'h00);
        // 128-byte mode: empty message and a short one
        write_mode(MODE_128);
        send_item(KIND_END, 8'h00);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'h01);
        send_item(KIND_END, 8'h7E);
        // mode switched back to 64-byte blocks in the middle of a message
        for (int i = 0; i < 6; i++)
            send_item(KIND_DATA, 8'($urandom_range(0, 255)));
        write_mode(MODE_64);
        send_item(KIND_DATA, 8'h80);
        send_item(KIND_DATA, 8'h7F);
        send_item(KIND_END, 8'hFF);

        // random messages: mostly short, now and then around the point where
        // the length field no longer fits and a second block is needed
        while (items_sent < TARGET_ITEMS) begin
            if ($urandom_range(0, 2) == 0)
                write_mode(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 4) == 0)
                length = ((stream.wide_blocks == MODE_128) ? 112 : 56)
                         + $urandom_range(0, 8) - 4;
            else
                length = $urandom_range(0, 14);
            // keep the run near the item budget, the end beat included
            room = unsigned'(TARGET_ITEMS - items_sent - 1);
            if (length > room)
                length = room;
            send_message(length);
        end

        let_block_settle();
        $display("sent %0d data beats and %0d message ends with %0d mode writes",
                 data_beats, end_beats, mode_writes);
        $display("checked %0d padded words, %0d mismatches",
                 stream.words_checked, stream.mismatches);
        if (stream.mismatches == 0 && stream.words_pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sha_message_padder.f =====
sv/shapad_pkg.sv
sv/shapad_ctrl.sv
sv/shapad_dp.sv
sv/sha_message_padder.sv
verif/padder_check_pkg.sv
verif/tb_sha_message_padder.sv
